/* rtl/core/text_console_line_editor_top_macros.svh */
// Assertion macros shared by the console line editor checkers
`ifndef TEXT_CONSOLE_LINE_EDITOR_TOP_MACROS_SVH
`define TEXT_CONSOLE_LINE_EDITOR_TOP_MACROS_SVH

// Check a property on every clock edge, with reset masking it
`define TCLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcle assertion failed");

// Check a property on every clock edge, reset included
`define TCLE_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tcle reset assertion failed");

`endif

/* rtl/core/tcle_pkg.sv */
// Shared constants and types of the text console line editor
package tcle_pkg;

    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_COLS  = 80;
    localparam int BUFFER_DEPTH = 32;

    localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int COL_W  = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
    localparam int CELL_W = $clog2(SCREEN_ROWS * SCREEN_COLS);
    localparam int BUF_AW = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] ATTR_RESET    = 8'h0c;
    localparam logic [7:0] KEY_BACKSPACE = 8'h0e;
    localparam logic [7:0] KEY_ENTER     = 8'h1c;
    localparam logic [7:0] KEY_LIMIT     = 8'h81;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0a;
    localparam logic [7:0] PRINT_LO      = 8'h20;
    localparam logic [7:0] PRINT_HI      = 8'h7e;

    localparam logic [1:0] RS_NONE      = 2'd0;
    localparam logic [1:0] RS_VALID     = 2'd1;
    localparam logic [1:0] RS_NOT_READY = 2'd2;

    typedef enum logic [1:0] {
        CMD_PRINT     = 2'd0,
        CMD_KEY       = 2'd1,
        CMD_READ_LINE = 2'd2,
        CMD_READ_CHAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic check;
        logic drain;
    } t_dp_ctrl;

    typedef struct packed {
        logic is_read;
        logic complete;
        logic drain_done;
    } t_dp_status;

    typedef struct packed {
        logic        cell_write;
        logic [10:0] cell_index;
        logic [15:0] cell_word;
        logic        low_byte_only;
        logic        scroll_request;
        logic        cursor_update;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [7:0]  read_char;
        logic [1:0]  read_status;
        logic        last;
    } t_result;

endpackage

/* rtl/core/tcle_ram.sv */
// Generic single-write, single-read RAM with registered read data
module tcle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/tcle_ctrl.sv */
// Controller state machine of the text console line editor
module tcle_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  tcle_pkg::t_dp_status  i_status,
    output tcle_pkg::t_dp_ctrl    o_ctrl,
    output logic                  o_busy
);

    tcle_pkg::t_state r_state;
    tcle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            tcle_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = tcle_pkg::ST_EXEC;
                end
            end
            tcle_pkg::ST_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_state     = i_status.is_read ? tcle_pkg::ST_CHECK : tcle_pkg::ST_IDLE;
            end
            tcle_pkg::ST_CHECK: begin
                o_ctrl.check = 1'b1;
                n_state      = i_status.complete ? tcle_pkg::ST_DRAIN : tcle_pkg::ST_IDLE;
            end
            tcle_pkg::ST_DRAIN: begin
                o_ctrl.drain = 1'b1;
                if (i_status.drain_done) begin
                    n_state = tcle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcle_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != tcle_pkg::ST_IDLE);

endmodule

/* rtl/core/tcle_dp.sv */
// Datapath: cursor, line buffer, attribute register and result register
module tcle_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcle_pkg::t_dp_ctrl    i_ctrl,
    output tcle_pkg::t_dp_status  o_status,
    input  logic [1:0]            i_command,
    input  logic [7:0]            i_character,
    input  logic [7:0]            i_scancode,
    input  logic                  i_end_of_string,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    output tcle_pkg::t_result     o_result,
    output logic                  o_result_valid
);

    localparam int ROW_W  = tcle_pkg::ROW_W;
    localparam int COL_W  = tcle_pkg::COL_W;
    localparam int CELL_W = tcle_pkg::CELL_W;
    localparam int BUF_AW = tcle_pkg::BUF_AW;
    localparam int FILL_W = tcle_pkg::FILL_W;

    // Latched item
    tcle_pkg::t_cmd r_cmd;
    logic [7:0]     r_char;
    logic [7:0]     r_scan;
    logic           r_eos;

    // Architectural state
    logic [ROW_W-1:0]  r_row,  n_row;
    logic [COL_W-1:0]  r_col,  n_col;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [BUF_AW-1:0] r_idx,  n_idx;
    logic [7:0]        r_attr;

    tcle_pkg::t_result r_res, n_res;
    logic              r_valid, n_valid;

    // Line buffer port signals
    logic              w_we;
    logic [7:0]        w_wdata;
    logic [BUF_AW-1:0] w_raddr;
    logic [7:0]        w_q;

    // Decode
    logic              w_is_read;
    logic              w_room;
    logic              w_print_key;
    logic              w_newline;
    logic              w_advance;
    logic              w_back;
    logic              w_scroll;
    logic              w_complete;
    logic              w_drain_done;
    logic [COL_W:0]    w_col_inc;
    logic [COL_W-1:0]  w_cell_col;
    logic [CELL_W-1:0] w_index;
    logic [FILL_W-1:0] w_fill_m1;

    tcle_ram #(
        .WIDTH (8),
        .DEPTH (tcle_pkg::BUFFER_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[BUF_AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_is_read = (r_cmd == tcle_pkg::CMD_READ_LINE) ||
                       (r_cmd == tcle_pkg::CMD_READ_CHAR);
    assign w_room    = (r_fill < FILL_W'(tcle_pkg::BUFFER_DEPTH));
    assign w_fill_m1 = FILL_W'(r_fill - 1'b1);
    assign w_print_key = (r_scan < tcle_pkg::KEY_LIMIT) &&
                         (r_char inside {[tcle_pkg::PRINT_LO:tcle_pkg::PRINT_HI]});
    assign w_col_inc = {1'b0, r_col} + 1'b1;

    always_comb begin
        w_newline = 1'b0;
        w_advance = 1'b0;
        w_back    = 1'b0;
        w_we      = 1'b0;
        w_wdata   = r_char;
        case (r_cmd)
            tcle_pkg::CMD_PRINT: begin
                if (r_char == tcle_pkg::CHAR_NEWLINE) begin
                    w_newline = 1'b1;
                end else begin
                    w_advance = 1'b1;
                end
            end
            tcle_pkg::CMD_KEY: begin
                if (r_scan == tcle_pkg::KEY_BACKSPACE) begin
                    w_back = (r_fill != '0) && (r_col != '0);
                end else if (r_scan == tcle_pkg::KEY_ENTER) begin
                    w_newline = w_room;
                    w_we      = w_room;
                    w_wdata   = tcle_pkg::CHAR_NEWLINE;
                end else if (w_print_key && w_room) begin
                    w_advance = 1'b1;
                    w_we      = 1'b1;
                end
            end
            default: begin
                w_newline = 1'b0;
            end
        endcase
        // Writes only land while executing a key item
        w_we = w_we && i_ctrl.exec;
    end

    // Cursor movement
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        w_scroll = 1'b0;
        if (i_ctrl.exec && !w_is_read) begin
            if (w_back) begin
                n_col = COL_W'(r_col - 1'b1);
            end else if (w_newline ||
                         (w_advance && (w_col_inc >= (COL_W+1)'(tcle_pkg::SCREEN_COLS)))) begin
                n_col = '0;
                if (r_row == ROW_W'(tcle_pkg::SCREEN_ROWS - 1)) begin
                    w_scroll = 1'b1;
                end else begin
                    n_row = ROW_W'(r_row + 1'b1);
                end
            end else if (w_advance) begin
                n_col = w_col_inc[COL_W-1:0];
            end
        end
    end

    assign w_cell_col = w_back ? COL_W'(r_col - 1'b1) : r_col;
    assign w_index    = CELL_W'(r_row) * CELL_W'(tcle_pkg::SCREEN_COLS) + CELL_W'(w_cell_col);

    // Read port: tail entry during exec, head during check, next entry while draining
    always_comb begin
        w_raddr = '0;
        if (i_ctrl.exec) begin
            w_raddr = w_fill_m1[BUF_AW-1:0];
        end else if (i_ctrl.drain) begin
            w_raddr = BUF_AW'(r_idx + 1'b1);
        end
    end

    assign w_complete   = (r_fill >= FILL_W'(2)) && (w_q == tcle_pkg::CHAR_NEWLINE);
    assign w_drain_done = (r_cmd == tcle_pkg::CMD_READ_CHAR) ||
                          (FILL_W'(r_idx) == w_fill_m1);

    assign o_status.is_read    = w_is_read;
    assign o_status.complete   = w_complete;
    assign o_status.drain_done = w_drain_done;

    // Fill count and drain index
    always_comb begin
        n_fill = r_fill;
        n_idx  = r_idx;
        if (i_ctrl.exec && !w_is_read) begin
            if (w_back) begin
                n_fill = FILL_W'(r_fill - 1'b1);
            end else if (w_we) begin
                n_fill = FILL_W'(r_fill + 1'b1);
            end
        end
        if (i_ctrl.check) begin
            n_idx = '0;
        end
        if (i_ctrl.drain) begin
            n_idx = BUF_AW'(r_idx + 1'b1);
            if (w_drain_done) begin
                n_fill = '0;
            end
        end
    end

    // Result assembly
    always_comb begin
        n_valid          = 1'b0;
        n_res            = '0;
        n_res.cursor_row = 5'(n_row);
        n_res.cursor_col = 7'(n_col);
        if (i_ctrl.exec && !w_is_read) begin
            n_valid              = 1'b1;
            n_res.cell_write     = w_advance || w_back;
            if (w_advance || w_back) begin
                n_res.cell_index = 11'(w_index);
                n_res.cell_word  = {r_attr, (w_back ? 8'h00 : r_char)};
            end
            n_res.low_byte_only  = w_advance && (r_cmd == tcle_pkg::CMD_KEY);
            n_res.scroll_request = w_scroll;
            n_res.cursor_update  = (r_cmd == tcle_pkg::CMD_KEY) ? 1'b1 : r_eos;
        end else if (i_ctrl.check && !w_complete) begin
            n_valid           = 1'b1;
            n_res.read_status = tcle_pkg::RS_NOT_READY;
            n_res.last        = 1'b1;
        end else if (i_ctrl.drain) begin
            if (r_cmd == tcle_pkg::CMD_READ_CHAR) begin
                n_valid           = 1'b1;
                n_res.read_char   = w_q;
                n_res.read_status = tcle_pkg::RS_VALID;
                n_res.last        = 1'b1;
            end else if (w_drain_done) begin
                // Tail entry is the newline: emit the terminator in its place
                n_valid           = 1'b1;
                n_res.read_status = tcle_pkg::RS_VALID;
                n_res.last        = 1'b1;
            end else if (w_q != tcle_pkg::CHAR_NEWLINE) begin
                n_valid           = 1'b1;
                n_res.read_char   = w_q;
                n_res.read_status = tcle_pkg::RS_VALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd  <= tcle_pkg::t_cmd'(i_command);
            r_char <= i_character;
            r_scan <= i_scancode;
            r_eos  <= i_end_of_string;
        end
        if (n_valid) begin
            r_res <= n_res;
        end
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_fill  <= '0;
            r_attr  <= tcle_pkg::ATTR_RESET;
            r_valid <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_fill  <= n_fill;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_valid;

endmodule

/* rtl/core/text_console_line_editor_top.sv */
// Top level of the text console line editor
// Print and key items: executed in the cycle after the transfer, result strobed in the cycle
// after that as busy drops; busy holds off the next item until then; results are never held off.
// Read line: the single RAM read port walks one entry per cycle (newlines give no result,
// the terminator comes as busy drops); read character and not-ready reads end the same way.
// Reset clears cursor, fill count and strobe, attribute 0x0C.
module text_console_line_editor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_character,
    input  logic [7:0]  i_scancode,
    input  logic        i_end_of_string,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic        o_result_valid,
    output logic        o_cell_write,
    output logic [10:0] o_cell_index,
    output logic [15:0] o_cell_word,
    output logic        o_low_byte_only,
    output logic        o_scroll_request,
    output logic        o_cursor_update,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic [7:0]  o_read_char,
    output logic [1:0]  o_read_status,
    output logic        o_last
);

    tcle_pkg::t_dp_ctrl   w_ctrl;
    tcle_pkg::t_dp_status w_status;
    tcle_pkg::t_result    w_result;

    tcle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (w_status),
        .o_ctrl   (w_ctrl),
        .o_busy   (o_busy)
    );

    tcle_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .o_status        (w_status),
        .i_command       (i_command),
        .i_character     (i_character),
        .i_scancode      (i_scancode),
        .i_end_of_string (i_end_of_string),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result        (w_result),
        .o_result_valid  (o_result_valid)
    );

    assign o_cell_write     = w_result.cell_write;
    assign o_cell_index     = w_result.cell_index;
    assign o_cell_word      = w_result.cell_word;
    assign o_low_byte_only  = w_result.low_byte_only;
    assign o_scroll_request = w_result.scroll_request;
    assign o_cursor_update  = w_result.cursor_update;
    assign o_cursor_row     = w_result.cursor_row;
    assign o_cursor_col     = w_result.cursor_col;
    assign o_read_char      = w_result.read_char;
    assign o_read_status    = w_result.read_status;
    assign o_last           = w_result.last;

endmodule

/* rtl/core/tcle_checker.sv */
// Port-level checker for the text console line editor, bound to the top level
`include "text_console_line_editor_top_macros.svh"

module tcle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_result_valid,
    input logic        o_cell_write,
    input logic [7:0]  o_read_char,
    input logic [1:0]  o_read_status,
    input logic        o_last
);

    // Reset leaves the block idle with no transfer pending
    `TCLE_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_busy && !o_result_valid)

    // An accepted item keeps the block busy for at least its execute cycle
    `TCLE_ASSERT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy |=> o_busy)

    // Every return to idle comes with a result transfer
    `TCLE_ASSERT(a_idle_result, i_clk, i_rst_n, $fell(o_busy) && $past(i_rst_n) |-> o_result_valid)

    // Cell writes never carry read fields
    `TCLE_ASSERT(a_cell_no_read, i_clk, i_rst_n, o_result_valid && o_cell_write |-> o_read_status == tcle_pkg::RS_NONE && !o_last)

    // A not-ready read is a single empty final transfer
    `TCLE_ASSERT(a_not_ready, i_clk, i_rst_n, o_result_valid && o_read_status == tcle_pkg::RS_NOT_READY |-> o_last && o_read_char == 8'd0)

endmodule

bind text_console_line_editor_top tcle_checker u_tcle_checker (.*);

/* sim/text_console_line_editor_top_tb.sv */
// Self-checking testbench for the text console line editor: predicts cells, cursor and reads

class console_scoreboard;
    localparam int MAX_LINE_BYTES = 31;

    tcle_pkg::t_result expected_q[$];
    logic [7:0]  attr;
    int unsigned row;
    int unsigned col;
    int unsigned fill;
    logic [7:0]  line_buf [tcle_pkg::BUFFER_DEPTH];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned lines_read;
    int unsigned not_ready_reads;

    function new();
        attr = tcle_pkg::ATTR_RESET;
        row = 0;
        col = 0;
        fill = 0;
        foreach (line_buf[i]) line_buf[i] = '0;
        mismatches = 0;
        results_checked = 0;
        lines_read = 0;
        not_ready_reads = 0;
    endfunction

    function void set_attribute(logic [7:0] value);
        attr = value;
    endfunction

    // Move down one row; report a scroll when already on the last row
    function logic next_line();
        col = 0;
        row++;
        if (row >= tcle_pkg::SCREEN_ROWS) begin
            row = tcle_pkg::SCREEN_ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void push_result(tcle_pkg::t_result r);
        r.cursor_row = 5'(row);
        r.cursor_col = 7'(col);
        expected_q.push_back(r);
    endfunction

    function void note_transfer(tcle_pkg::t_cmd cmd, logic [7:0] ch, logic [7:0] sc,
                                logic eos);
        tcle_pkg::t_result r;
        int unsigned n;
        r = '0;
        case (cmd)
            tcle_pkg::CMD_PRINT: begin
                r.cursor_update = eos;
                if (ch == tcle_pkg::CHAR_NEWLINE) begin
                    r.scroll_request = next_line();
                end else begin
                    r.cell_write = 1'b1;
                    r.cell_index = 11'(row * tcle_pkg::SCREEN_COLS + col);
                    r.cell_word  = {attr, ch};
                    col++;
                    if (col >= tcle_pkg::SCREEN_COLS) r.scroll_request = next_line();
                end
                push_result(r);
            end
            tcle_pkg::CMD_KEY: begin
                r.cursor_update = 1'b1;
                if (sc == tcle_pkg::KEY_BACKSPACE) begin
                    if (fill >= 1 && col > 0) begin
                        col--;
                        fill--;
                        line_buf[fill] = '0;
                        r.cell_write = 1'b1;
                        r.cell_index = 11'(row * tcle_pkg::SCREEN_COLS + col);
                        r.cell_word  = {attr, 8'h00};
                    end
                end else if (sc == tcle_pkg::KEY_ENTER) begin
                    if (fill < tcle_pkg::BUFFER_DEPTH) begin
                        line_buf[fill] = tcle_pkg::CHAR_NEWLINE;
                        fill++;
                        r.scroll_request = next_line();
                    end
                end else if (sc < tcle_pkg::KEY_LIMIT && ch >= tcle_pkg::PRINT_LO &&
                             ch <= tcle_pkg::PRINT_HI && fill < tcle_pkg::BUFFER_DEPTH) begin
                    line_buf[fill] = ch;
                    fill++;
                    r.cell_write    = 1'b1;
                    r.low_byte_only = 1'b1;
                    r.cell_index    = 11'(row * tcle_pkg::SCREEN_COLS + col);
                    r.cell_word     = {attr, ch};
                    col++;
                    if (col >= tcle_pkg::SCREEN_COLS) r.scroll_request = next_line();
                end
                push_result(r);
            end
            default: begin
                if (fill < 2 || line_buf[fill - 1] != tcle_pkg::CHAR_NEWLINE) begin
                    // line not complete: single not-ready result, buffer kept
                    r.read_status = tcle_pkg::RS_NOT_READY;
                    r.last = 1'b1;
                    push_result(r);
                    not_ready_reads++;
                end else begin
                    if (cmd == tcle_pkg::CMD_READ_CHAR) begin
                        r.read_char   = line_buf[0];
                        r.read_status = tcle_pkg::RS_VALID;
                        r.last        = 1'b1;
                        push_result(r);
                    end else begin
                        n = 0;
                        r.read_status = tcle_pkg::RS_VALID;
                        for (int i = 0; i < fill; i++) begin
                            if (line_buf[i] != 8'h00 &&
                                line_buf[i] != tcle_pkg::CHAR_NEWLINE &&
                                n < MAX_LINE_BYTES) begin
                                r.read_char = line_buf[i];
                                push_result(r);
                                n++;
                            end
                        end
                        r.read_char = 8'h00;
                        r.last = 1'b1;
                        push_result(r);
                    end
                    foreach (line_buf[i]) line_buf[i] = '0;
                    fill = 0;
                    lines_read++;
                end
            end
        endcase
    endfunction

    function string describe(tcle_pkg::t_result x);
        string cell_part;
        cell_part = $sformatf("cw=%0d idx=%0d word=%h lbo=%0d scr=%0d cu=%0d ",
                              x.cell_write, x.cell_index, x.cell_word, x.low_byte_only,
                              x.scroll_request, x.cursor_update);
        return {cell_part, $sformatf("row=%0d col=%0d rc=%h rs=%0d last=%0d",
                                     x.cursor_row, x.cursor_col, x.read_char,
                                     x.read_status, x.last)};
    endfunction

    function void check_result(tcle_pkg::t_result got);
        tcle_pkg::t_result want;
        results_checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with nothing pending: %s", describe(got));
        end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d mismatch", results_checked);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        end
    endfunction
endclass

module text_console_line_editor_top_tb;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_command;
    logic [7:0]  i_character;
    logic [7:0]  i_scancode;
    logic        i_end_of_string;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        o_result_valid;
    logic        o_cell_write;
    logic [10:0] o_cell_index;
    logic [15:0] o_cell_word;
    logic        o_low_byte_only;
    logic        o_scroll_request;
    logic        o_cursor_update;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic [7:0]  o_read_char;
    logic [1:0]  o_read_status;
    logic        o_last;

    console_scoreboard sb = new();
    int unsigned items_sent = 0;
    int unsigned burst_left = 1;
    int unsigned idle_cycles = 0;

    text_console_line_editor_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_character     (i_character),
        .i_scancode      (i_scancode),
        .i_end_of_string (i_end_of_string),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_valid  (o_result_valid),
        .o_cell_write    (o_cell_write),
        .o_cell_index    (o_cell_index),
        .o_cell_word     (o_cell_word),
        .o_low_byte_only (o_low_byte_only),
        .o_scroll_request(o_scroll_request),
        .o_cursor_update (o_cursor_update),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_col    (o_cursor_col),
        .o_read_char     (o_read_char),
        .o_read_status   (o_read_status),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_result_valid === 1'b1) begin
                sb.check_result('{o_cell_write, o_cell_index, o_cell_word, o_low_byte_only,
                                  o_scroll_request, o_cursor_update, o_cursor_row,
                                  o_cursor_col, o_read_char, o_read_status, o_last});
            end
            if ((i_start && o_busy === 1'b0) || o_result_valid === 1'b1) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results pending",
                         idle_cycles, sb.expected_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Hold the item until the block takes it, then pace the sender in bursts
    task automatic send(tcle_pkg::t_cmd cmd, logic [7:0] ch, logic [7:0] sc, logic eos);
        i_start         <= 1'b1;
        i_command       <= cmd;
        i_character     <= ch;
        i_scancode      <= sc;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        sb.note_transfer(cmd, ch, sc, eos);
        items_sent++;
        burst_left--;
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Write the attribute only with the block idle and every result in
    task automatic write_attribute(logic [7:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_attribute(value);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic key(logic [7:0] ch, logic [7:0] sc);
        send(tcle_pkg::CMD_KEY, ch, sc, 1'($urandom_range(0, 1)));
    endtask

    task automatic read_any();
        send(tcle_pkg::t_cmd'($urandom_range(0, 1) ? tcle_pkg::CMD_READ_LINE
                                                   : tcle_pkg::CMD_READ_CHAR),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    endtask

    // Printable keys with an occasional backspace
    task automatic type_keys(int unsigned len);
        logic [7:0] sc;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                key(8'($urandom_range(0, 255)), tcle_pkg::KEY_BACKSPACE);
            end else begin
                do sc = 8'($urandom_range(0, 8'h80));
                while (sc == tcle_pkg::KEY_BACKSPACE || sc == tcle_pkg::KEY_ENTER);
                key(8'($urandom_range(tcle_pkg::PRINT_LO, tcle_pkg::PRINT_HI)), sc);
            end
        end
    endtask

    task automatic print_string(int unsigned len, bit allow_newline);
        logic [7:0] ch;
        for (int unsigned i = 0; i < len; i++) begin
            if (allow_newline && $urandom_range(0, 5) == 0) begin
                ch = tcle_pkg::CHAR_NEWLINE;
            end else begin
                do ch = 8'($urandom_range(0, 255));
                while (!allow_newline && ch == tcle_pkg::CHAR_NEWLINE);
            end
            send(tcle_pkg::CMD_PRINT, ch, 8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    initial begin
        logic [7:0] phase_attr [4];
        int unsigned phase_base;

        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_command       <= tcle_pkg::CMD_PRINT;
        i_character     <= '0;
        i_scancode      <= '0;
        i_end_of_string <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the reset attribute
        send(tcle_pkg::CMD_PRINT, 8'h48, 8'h00, 1'b0);
        send(tcle_pkg::CMD_PRINT, 8'h00, 8'hff, 1'b0);
        send(tcle_pkg::CMD_PRINT, 8'hff, 8'h00, 1'b1);
        send(tcle_pkg::CMD_PRINT, tcle_pkg::CHAR_NEWLINE, 8'h00, 1'b1);
        send(tcle_pkg::CMD_READ_LINE, 8'h00, 8'h00, 1'b0);   // empty buffer: not ready
        send(tcle_pkg::CMD_KEY, 8'h00, tcle_pkg::KEY_ENTER, 1'b0); // lone newline
        send(tcle_pkg::CMD_READ_CHAR, 8'hff, 8'hff, 1'b1);
        send(tcle_pkg::CMD_KEY, 8'h41, tcle_pkg::KEY_BACKSPACE, 1'b0); // column 0: no erase
        send(tcle_pkg::CMD_KEY, tcle_pkg::PRINT_LO, 8'h10, 1'b0);
        send(tcle_pkg::CMD_KEY, tcle_pkg::PRINT_HI, 8'h80, 1'b1);
        send(tcle_pkg::CMD_KEY, 8'h41, tcle_pkg::KEY_LIMIT, 1'b0);
        send(tcle_pkg::CMD_KEY, 8'h41, 8'hff, 1'b0);
        send(tcle_pkg::CMD_KEY, 8'h1f, 8'h1e, 1'b0);
        send(tcle_pkg::CMD_KEY, 8'h7f, 8'h1e, 1'b0);
        send(tcle_pkg::CMD_KEY, 8'h61, 8'h00, 1'b0);
        send(tcle_pkg::CMD_KEY, 8'h00, tcle_pkg::KEY_BACKSPACE, 1'b0);
        send(tcle_pkg::CMD_READ_LINE, 8'h00, 8'h00, 1'b0);   // newest byte not a newline
        send(tcle_pkg::CMD_KEY, 8'h00, tcle_pkg::KEY_ENTER, 1'b0);
        send(tcle_pkg::CMD_READ_LINE, 8'h00, 8'h00, 1'b0);
        send(tcle_pkg::CMD_KEY, 8'h00, tcle_pkg::KEY_ENTER, 1'b0);
        send(tcle_pkg::CMD_KEY, 8'h00, tcle_pkg::KEY_ENTER, 1'b0);
        send(tcle_pkg::CMD_READ_CHAR, 8'h00, 8'h00, 1'b0);   // first byte is a newline
        send(tcle_pkg::CMD_KEY, 8'h78, 8'h2d, 1'b0);
        send(tcle_pkg::CMD_KEY, 8'h00, tcle_pkg::KEY_ENTER, 1'b0);
        send(tcle_pkg::CMD_READ_CHAR, 8'h00, 8'h00, 1'b0);

        phase_attr[0] = 8'hff;
        phase_attr[1] = 8'h00;
        phase_attr[2] = 8'($urandom_range(0, 255));
        phase_attr[3] = 8'($urandom_range(0, 255));
        for (int ph = 0; ph < 4; ph++) begin
            write_attribute(phase_attr[ph]);
            phase_base = items_sent;
            // one full row of text forces a column wrap
            if (ph == 0) print_string(tcle_pkg::SCREEN_COLS, 1'b0);
            while (items_sent < phase_base + ITEMS_PER_PHASE) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        type_keys(($urandom_range(0, 5) == 0) ? $urandom_range(28, 40)
                                                              : $urandom_range(0, 12));
                        key(8'($urandom_range(0, 255)), tcle_pkg::KEY_ENTER);
                        read_any();
                    end
                    5, 6: print_string($urandom_range(1, 20), 1'b1);
                    7: begin
                        repeat ($urandom_range(1, 6))
                            send(tcle_pkg::t_cmd'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    end
                    8: begin
                        type_keys($urandom_range(0, 5));
                        read_any();
                    end
                    default: begin
                        repeat ($urandom_range(1, 3))
                            key(8'($urandom_range(0, 255)), tcle_pkg::KEY_ENTER);
                        read_any();
                    end
                endcase
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("run covered %0d items, %0d results checked, 5 attribute settings",
                 items_sent, sb.results_checked);
        $display("reads: %0d drained lines, %0d not-ready answers",
                 sb.lines_read, sb.not_ready_reads);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     sb.mismatches, sb.expected_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
